/* rtl/core/dfa_byte_class_matcher_unit_assert.svh */
// Assertion macros shared by the matcher RTL.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef DFA_BYTE_CLASS_MATCHER_UNIT_ASSERT_SVH
`define DFA_BYTE_CLASS_MATCHER_UNIT_ASSERT_SVH

// A property that must hold at every sampled edge.
`define DBCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition at one edge that requires an expression to hold at the next edge.
`define DBCM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/core/dbcm_pkg.sv */
`default_nettype none

package dbcm_pkg;

    localparam int STATE_W       = 12;
    localparam int STATE_SLOTS   = 4096;
    localparam int CLASS_ENTRIES = 256;
    localparam int TRANS_AW      = $clog2(STATE_SLOTS);
    localparam int CLASS_AW      = $clog2(CLASS_ENTRIES);
    localparam int IDX_W         = STATE_W + 1;
    localparam int APB_AW        = 4;

    localparam logic [STATE_W-1:0] START_RESET = 12'd1;

    // Item kinds carried on func.
    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_END      = 2'd1;
    localparam logic [1:0] FUNC_CLASS_WR = 2'd2;
    localparam logic [1:0] FUNC_TRANS_WR = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_STATE = 2'd0;
    localparam logic [1:0] REG_END_CLASS   = 2'd1;
    localparam logic [1:0] REG_ACCEPT_LOW  = 2'd2;
    localparam logic [1:0] REG_ACCEPT_HIGH = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] start_state;
        logic [STATE_W-1:0] end_class;
        logic [STATE_W-1:0] accept_low;
        logic [STATE_W-1:0] accept_high;
    } cfg_t;

    // True when a transition index falls inside the table.
    function automatic logic in_slots(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(STATE_SLOTS);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dbcm_ram.sv */
`default_nettype none

module dbcm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/dbcm_cfg_regs.sv */
`default_nettype none

module dbcm_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dbcm_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output dbcm_pkg::cfg_t                   cfg
);

    dbcm_pkg::cfg_t cfg_reg;
    dbcm_pkg::cfg_t cfg_next;
    logic [1:0]     reg_idx;
    logic           wr_en;
    logic [dbcm_pkg::STATE_W-1:0] wval;
    logic [dbcm_pkg::STATE_W-1:0] rval;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign wval    = pwdata[dbcm_pkg::STATE_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dbcm_pkg::REG_START_STATE: cfg_next.start_state = wval;
                dbcm_pkg::REG_END_CLASS:   cfg_next.end_class   = wval;
                dbcm_pkg::REG_ACCEPT_LOW:  cfg_next.accept_low  = wval;
                dbcm_pkg::REG_ACCEPT_HIGH: cfg_next.accept_high = wval;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dbcm_pkg::REG_START_STATE: rval = cfg_reg.start_state;
            dbcm_pkg::REG_END_CLASS:   rval = cfg_reg.end_class;
            dbcm_pkg::REG_ACCEPT_LOW:  rval = cfg_reg.accept_low;
            dbcm_pkg::REG_ACCEPT_HIGH: rval = cfg_reg.accept_high;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_state <= dbcm_pkg::START_RESET;
            cfg_reg.end_class   <= '0;
            cfg_reg.accept_low  <= '0;
            cfg_reg.accept_high <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = 32'(rval);
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/dfa_byte_class_matcher_unit.sv */
`default_nettype none
// Channel   Handshake             Payload
// input     in_valid / in_stall   func, symbol, table_address, table_data
// output    out_valid / out_stall current_state, is_dead, matched, at_end
// config    APB, pready tied high start_state, end_class, accept_low, accept_high
//
// One item is taken per cycle when nothing stalls; an accepted beat passes
// through stage A, stage B and the output stage before out_valid rises.
// The rate is set by the loop through the
// transition memory: its registered read data is the state, and the next index
// is formed from it combinationally. Reset clears the pipeline, loads the
// start state and leaves both tables undefined until they are written. A stall
// on the output lets the three stages fill one by one before the input stalls.

`include "dfa_byte_class_matcher_unit_assert.svh"

module dfa_byte_class_matcher_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   func,
    input  wire logic [7:0]                   symbol,
    input  wire logic [11:0]                  table_address,
    input  wire logic [11:0]                  table_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [11:0]                  current_state,
    output logic                              is_dead,
    output logic                              matched,
    output logic                              at_end,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dbcm_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int SW = dbcm_pkg::STATE_W;

    dbcm_pkg::cfg_t cfg;

    // Pipeline flow control. Stage A holds the class lookup, stage B the
    // transition lookup, and the output stage the finished result beat.
    logic valid_a_reg, valid_a_next;
    logic valid_b_reg, valid_b_next;
    logic valid_o_reg, valid_o_next;
    logic ready_o, ready_b, ready_a;
    logic move_a, move_b, accept;

    // Stage A payload.
    logic [1:0]    func_a_reg;
    logic [11:0]   addr_a_reg;
    logic [11:0]   data_a_reg;

    // The automaton state is either the transition memory's read data or a
    // held value (the start state after an end item, or dead).
    logic          use_ram_reg, use_ram_next;
    logic [SW-1:0] hold_reg, hold_next;

    // Stage B payload: where the shown state comes from, and what to report.
    logic          shown_ram_b_reg, shown_ram_b_next;
    logic [SW-1:0] shown_hold_b_reg, shown_hold_b_next;
    logic          at_end_b_reg, at_end_b_next;
    logic          chk_b_reg, chk_b_next;

    // Output stage payload.
    logic [SW-1:0] state_o_reg, state_o_next;
    logic          matched_o_reg, matched_o_next;
    logic          at_end_o_reg, at_end_o_next;

    logic [SW-1:0] class_rdata;
    logic [SW-1:0] trans_rdata;
    logic          class_we, class_re;
    logic          trans_we, trans_re;

    logic [SW-1:0]                live_state;
    logic [SW-1:0]                offset;
    logic [dbcm_pkg::IDX_W-1:0]   idx;
    logic                         hit;
    logic [SW-1:0]                shown_b;

    assign ready_o  = !valid_o_reg || !out_stall;
    assign move_b   = valid_b_reg && ready_o;
    assign ready_b  = !valid_b_reg || ready_o;
    assign move_a   = valid_a_reg && ready_b;
    assign ready_a  = !valid_a_reg || ready_b;
    assign accept   = in_valid && ready_a;
    assign in_stall = !ready_a;

    dbcm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // The class table is read as a byte beat is accepted, so the class is
    // ready when the item sits in stage A. Writes out of range are dropped.
    assign class_re = accept && (func == dbcm_pkg::FUNC_BYTE);
    assign class_we = accept && (func == dbcm_pkg::FUNC_CLASS_WR) &&
                      (32'(table_address) < 32'(dbcm_pkg::CLASS_ENTRIES));

    dbcm_ram #(
        .WIDTH (SW),
        .DEPTH (dbcm_pkg::CLASS_ENTRIES)
    ) u_class_ram (
        .clk   (clk),
        .we    (class_we),
        .waddr (dbcm_pkg::CLASS_AW'(table_address)),
        .wdata (table_data),
        .re    (class_re),
        .raddr (dbcm_pkg::CLASS_AW'(symbol)),
        .rdata (class_rdata)
    );

    // The state loop: the live state feeds the index adder, and the memory
    // read issued here, once registered, becomes the next live state. Reads and
    // writes of the transition table both happen as an item leaves stage A,
    // so they keep item order without any forwarding.
    assign live_state = use_ram_reg ? trans_rdata : hold_reg;
    assign offset     = (func_a_reg == dbcm_pkg::FUNC_END) ? cfg.end_class : class_rdata;
    assign idx        = {1'b0, live_state} + {1'b0, offset};
    assign hit        = (live_state != '0) && dbcm_pkg::in_slots(idx);

    assign trans_re = move_a && hit &&
                      ((func_a_reg == dbcm_pkg::FUNC_BYTE) ||
                       (func_a_reg == dbcm_pkg::FUNC_END));
    assign trans_we = move_a && (func_a_reg == dbcm_pkg::FUNC_TRANS_WR) &&
                      dbcm_pkg::in_slots({1'b0, addr_a_reg});

    dbcm_ram #(
        .WIDTH (SW),
        .DEPTH (dbcm_pkg::STATE_SLOTS)
    ) u_trans_ram (
        .clk   (clk),
        .we    (trans_we),
        .waddr (dbcm_pkg::TRANS_AW'(addr_a_reg)),
        .wdata (data_a_reg),
        .re    (trans_re),
        .raddr (dbcm_pkg::TRANS_AW'(idx)),
        .rdata (trans_rdata)
    );

    // Stage A decision: the new state and the origin of the shown value.
    always_comb
    begin
        use_ram_next      = use_ram_reg;
        hold_next         = hold_reg;
        shown_ram_b_next  = shown_ram_b_reg;
        shown_hold_b_next = shown_hold_b_reg;
        at_end_b_next     = at_end_b_reg;
        chk_b_next        = chk_b_reg;
        if (move_a)
        begin
            unique case (func_a_reg)
                dbcm_pkg::FUNC_BYTE:
                begin
                    // A dead state or an index beyond the table both give dead.
                    use_ram_next      = hit;
                    hold_next         = '0;
                    shown_ram_b_next  = hit;
                    shown_hold_b_next = '0;
                    at_end_b_next     = 1'b0;
                    chk_b_next        = 1'b0;
                end
                dbcm_pkg::FUNC_END:
                begin
                    use_ram_next      = 1'b0;
                    hold_next         = cfg.start_state;
                    shown_ram_b_next  = hit;
                    shown_hold_b_next = '0;
                    at_end_b_next     = 1'b1;
                    chk_b_next        = (live_state != '0);
                end
                dbcm_pkg::FUNC_CLASS_WR,
                dbcm_pkg::FUNC_TRANS_WR:
                begin
                    // Table writes report the state unchanged.
                    shown_ram_b_next  = use_ram_reg;
                    shown_hold_b_next = hold_reg;
                    at_end_b_next     = 1'b0;
                    chk_b_next        = 1'b0;
                end
            endcase
        end
    end

    // Stage B: the read data is final here, so the result beat is formed.
    assign shown_b = shown_ram_b_reg ? trans_rdata : shown_hold_b_reg;

    always_comb
    begin
        state_o_next   = state_o_reg;
        matched_o_next = matched_o_reg;
        at_end_o_next  = at_end_o_reg;
        if (move_b)
        begin
            state_o_next   = shown_b;
            matched_o_next = chk_b_reg && (cfg.accept_low <= shown_b) &&
                             (shown_b <= cfg.accept_high);
            at_end_o_next  = at_end_b_reg;
        end
    end

    always_comb
    begin
        valid_a_next = accept || (valid_a_reg && !move_a);
        valid_b_next = move_a || (valid_b_reg && !move_b);
        valid_o_next = move_b || (valid_o_reg && !ready_o);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_o_reg <= 1'b0;
            use_ram_reg <= 1'b0;
            hold_reg    <= dbcm_pkg::START_RESET;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
            valid_o_reg <= valid_o_next;
            use_ram_reg <= use_ram_next;
            hold_reg    <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_a_reg <= func;
            addr_a_reg <= table_address;
            data_a_reg <= table_data;
        end
        shown_ram_b_reg  <= shown_ram_b_next;
        shown_hold_b_reg <= shown_hold_b_next;
        at_end_b_reg     <= at_end_b_next;
        chk_b_reg        <= chk_b_next;
        state_o_reg      <= state_o_next;
        matched_o_reg    <= matched_o_next;
        at_end_o_reg     <= at_end_o_next;
    end

    assign out_valid     = valid_o_reg;
    assign current_state = state_o_reg;
    assign is_dead       = (state_o_reg == '0);
    assign matched       = matched_o_reg;
    assign at_end        = at_end_o_reg;

    // An empty pipeline must always take a beat.
    `DBCM_ASSERT(a_empty_takes_beat, (!valid_a_reg && !valid_b_reg && !valid_o_reg) |-> !in_stall, "empty pipeline stalls the input")
    // An accepted beat lands in stage A.
    `DBCM_ASSERT_NEXT(a_accept_fills_a, in_valid && !in_stall, valid_a_reg, "accepted beat lost before stage A")
    // A byte beat held in stage A keeps its class lookup.
    `DBCM_ASSERT_NEXT(a_class_held, valid_a_reg && !move_a && (func_a_reg == dbcm_pkg::FUNC_BYTE), $stable(class_rdata), "class data changed under a held item")
    // A held stage B that reports the read data keeps it until it leaves.
    `DBCM_ASSERT_NEXT(a_trans_held, valid_b_reg && !move_b && shown_ram_b_reg, $stable(trans_rdata), "transition data changed under a held item")

endmodule

`default_nettype wire
